// File: hdl/throttle_scale_speed_ramp_core_macros.svh
// Assertion macros used by the throttle scale and ramp controller.
`ifndef THROTTLE_SCALE_SPEED_RAMP_CORE_MACROS_SVH
`define THROTTLE_SCALE_SPEED_RAMP_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tsr_pkg.sv
// Types, constants and codes for the throttle scale and ramp core.
`default_nettype none

package tsr_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SPEED_W  = 17;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned LEVEL_W  = 14;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned BLEND_W  = 10;

  // shared divider
  localparam int unsigned DIV_W = 26;
  localparam int unsigned DVS_W = 17;
  localparam int unsigned CNT_W = 5;

  localparam logic [CNT_W-1:0] NBITS_TGT  = 5'd24;
  localparam logic [CNT_W-1:0] NBITS_F    = 5'd17;
  localparam logic [CNT_W-1:0] NBITS_STEP = 5'd14;

  // arithmetic constants
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 14'd10000;
  localparam logic [LEVEL_W-1:0] BLOCK_LEVEL = 14'd5000;
  localparam logic [BLEND_W-1:0] BLEND_ONE   = 10'd1000;
  localparam logic [8:0]         DUTY_BASE   = 9'd25;
  localparam logic [DUTY_W-1:0]  DUTY_MAX    = 8'd255;
  // ceil(2^20 / 55): exact floor(x / 55) for x below 19418
  localparam logic [14:0]        DUTY_RECIP  = 15'd19066;
  // ceil(2^36 / 1000): exact floor(x / 1000) for x below 2^26
  localparam logic [26:0]        T_RECIP     = 27'd68719477;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_FAST  = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_SCALE_MIN = 10'd180;
  localparam logic [SAMPLE_W-1:0] RST_SCALE_MAX = 10'd870;
  localparam logic [SPEED_W-1:0]  RST_SPEED_LIM = 17'd25000;
  localparam logic [TIME_W-1:0]   RST_TIME_SLOW = 16'd1000;
  localparam logic [TIME_W-1:0]   RST_TIME_FAST = 16'd3000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CHK,
    S_BLEND,
    S_TMUL,
    S_TCHK,
    S_LVL,
    S_OUT
  } tsr_state_t;

  typedef enum logic [1:0] {
    OP_TGT,   // offset * 10000 / span
    OP_F,     // speed / limit
    OP_STEP   // 10000 / t
  } tsr_div_op_t;

  typedef enum logic [1:0] {
    LVL_HOLD,
    LVL_TARGET,
    LVL_STEP
  } tsr_lvl_mode_t;

  typedef struct packed {
    logic          load_in;
    logic          prod_en;
    logic          div_start;
    tsr_div_op_t   div_op;
    logic          div_cap;
    logic          blend_en;
    logic          t_load;
    logic          lvl_we;
    tsr_lvl_mode_t lvl_mode;
    logic          out_load;
  } tsr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tgt_lt;
    logic tgt_gt;
    logic limit_zero;
    logic t_zero;
  } tsr_sts_t;

endpackage

`default_nettype wire

// File: hdl/tsr_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module tsr_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tsr_pkg::DIV_W-1:0]  dividend,  // MSB-aligned to nbits
  input  wire logic [tsr_pkg::DVS_W-1:0]  divisor,
  input  wire logic [tsr_pkg::CNT_W-1:0]  nbits,
  output logic                            done,
  output logic [tsr_pkg::DIV_W-1:0]       quotient
);
  import tsr_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] d_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W+1:0] trial;
  logic             fits;
  logic [DVS_W-1:0] rem_nxt;

  assign trial   = {1'b0, rem_r, d_r[DIV_W-1]} - {2'b00, dvs_r};
  assign fits    = !trial[DVS_W+1];
  assign rem_nxt = fits ? trial[DVS_W-1:0] : {rem_r[DVS_W-2:0], d_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      d_r   <= {d_r[DIV_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = d_r;

endmodule

`default_nettype wire

// File: hdl/tsr_datapath.sv
// Datapath: config registers, target scaling, ramp arithmetic and result register.
`default_nettype none

module tsr_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tsr_pkg::tsr_cmd_t                  cmd,
  output tsr_pkg::tsr_sts_t                       sts,
  input  wire logic                               cfg_we,
  input  wire logic [tsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tsr_pkg::SPEED_W-1:0]        cfg_data,
  input  wire logic [tsr_pkg::SAMPLE_W-1:0]       throttle_sample,
  input  wire logic [tsr_pkg::SPEED_W-1:0]        vehicle_speed,
  input  wire logic                               road_mode,
  output logic [tsr_pkg::LEVEL_W-1:0]             throttle_level,
  output logic [tsr_pkg::DUTY_W-1:0]              pwm_duty,
  output logic                                    assist_blocked
);
  import tsr_pkg::*;

  logic [SAMPLE_W-1:0] scale_min_r, scale_max_r;
  logic [SPEED_W-1:0]  speed_lim_r;
  logic [TIME_W-1:0]   time_slow_r, time_fast_r;

  logic [SAMPLE_W-1:0] sample_r;
  logic [SPEED_W-1:0]  speed_r;
  logic                road_r;
  logic [23:0]         prod_r;
  logic [LEVEL_W-1:0]  target_r;
  logic [BLEND_W-1:0]  f_r;
  logic [DIV_W-1:0]    p_slow_r, p_fast_r;
  logic [TIME_W-1:0]   t_r;
  logic [LEVEL_W-1:0]  step_r;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [DUTY_W-1:0]   out_duty_r;
  logic                out_blk_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_min_r <= RST_SCALE_MIN;
      scale_max_r <= RST_SCALE_MAX;
      speed_lim_r <= RST_SPEED_LIM;
      time_slow_r <= RST_TIME_SLOW;
      time_fast_r <= RST_TIME_FAST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_MIN: scale_min_r <= cfg_data[SAMPLE_W-1:0];
        CFG_SCALE_MAX: scale_max_r <= cfg_data[SAMPLE_W-1:0];
        CFG_SPEED_LIM: speed_lim_r <= cfg_data;
        CFG_TIME_SLOW: time_slow_r <= cfg_data[TIME_W-1:0];
        CFG_TIME_FAST: time_fast_r <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // offset, span
  logic [SAMPLE_W-1:0] offset;
  logic [SAMPLE_W-1:0] span;
  logic                span_zero, span_neg;

  assign offset    = (sample_r > scale_min_r) ? (sample_r - scale_min_r) : '0;
  assign span      = scale_max_r - scale_min_r;
  assign span_zero = (scale_max_r == scale_min_r);
  assign span_neg  = (scale_max_r < scale_min_r);

  // divider operands, MSB-aligned per operation
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic [CNT_W-1:0]   div_nbits;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W-1:0]   blend_sum;
  logic [51:0]        t_prod;

  // both products together stay at most 65535 * 1000, no carry out
  assign blend_sum = p_slow_r + p_fast_r;

  // t = blend / 1000 via reciprocal multiply
  assign t_prod = 52'(blend_sum) * 52'(T_RECIP);

  always_comb begin
    case (cmd.div_op)
      OP_TGT: begin
        div_dividend = {prod_r, 2'b00};
        div_divisor  = DVS_W'(span);
        div_nbits    = NBITS_TGT;
      end
      OP_F: begin
        div_dividend = {speed_r, 9'd0};
        div_divisor  = speed_lim_r;
        div_nbits    = NBITS_F;
      end
      OP_STEP: begin
        div_dividend = {FULL_LEVEL, 12'd0};
        div_divisor  = {1'b0, t_r};
        div_nbits    = NBITS_STEP;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_nbits    = '0;
      end
    endcase
  end

  tsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .done     (div_done),
    .quotient (div_q)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= throttle_sample;
      speed_r  <= vehicle_speed;
      road_r   <= road_mode;
    end
    if (cmd.prod_en)
      prod_r <= 24'(offset) * 24'(FULL_LEVEL);
    if (cmd.blend_en) begin
      p_slow_r <= DIV_W'(time_slow_r) * DIV_W'(BLEND_ONE - f_r);
      p_fast_r <= DIV_W'(time_fast_r) * DIV_W'(f_r);
    end
    if (cmd.t_load)
      t_r <= t_prod[51:36];
    if (cmd.div_cap) begin
      case (cmd.div_op)
        OP_TGT: begin
          if (span_zero)
            target_r <= FULL_LEVEL;
          else if (span_neg)
            target_r <= '0;
          else if (div_q > DIV_W'(FULL_LEVEL))
            target_r <= FULL_LEVEL;
          else
            target_r <= div_q[LEVEL_W-1:0];
        end
        OP_F:    f_r    <= (div_q > DIV_W'(BLEND_ONE)) ? BLEND_ONE : div_q[BLEND_W-1:0];
        OP_STEP: step_r <= div_q[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // level update
  logic [LEVEL_W:0] stepped;

  assign stepped = {1'b0, level_r} + {1'b0, step_r};

  always_comb begin
    case (cmd.lvl_mode)
      LVL_TARGET: level_nxt = target_r;
      LVL_STEP:   level_nxt = (stepped > {1'b0, target_r}) ? target_r
                                                           : stepped[LEVEL_W-1:0];
      default:    level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      level_r <= '0;
    else if (cmd.lvl_we)
      level_r <= level_nxt;
  end

  // duty = 25 + level/55 via reciprocal multiply
  logic [28:0] duty_prod;
  logic [8:0]  duty_sum;

  assign duty_prod = 29'(level_r) * 29'(DUTY_RECIP);
  assign duty_sum  = DUTY_BASE + duty_prod[28:20];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level_r <= level_r;
      if (road_r)
        out_duty_r <= '0;
      else if (duty_sum > 9'(DUTY_MAX))
        out_duty_r <= DUTY_MAX;
      else
        out_duty_r <= duty_sum[DUTY_W-1:0];
      out_blk_r <= road_r && (level_r >= BLOCK_LEVEL);
    end
  end

  assign sts.div_done   = div_done;
  assign sts.tgt_lt     = (target_r < level_r);
  assign sts.tgt_gt     = (target_r > level_r);
  assign sts.limit_zero = (speed_lim_r == '0);
  assign sts.t_zero     = (t_r == '0);

  assign throttle_level = out_level_r;
  assign pwm_duty       = out_duty_r;
  assign assist_blocked = out_blk_r;

endmodule

`default_nettype wire

// File: hdl/tsr_ctrl.sv
// Controller FSM: sequences scaling, the ramp divisions and the result handshake.
`default_nettype none

`include "throttle_scale_speed_ramp_core_macros.svh"

module tsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output tsr_pkg::tsr_cmd_t      cmd,
  input  wire tsr_pkg::tsr_sts_t sts
);
  import tsr_pkg::*;

  tsr_state_t    state_r, state_nxt;
  tsr_div_op_t   op_r, op_nxt;
  tsr_lvl_mode_t mode_r, mode_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TGT;
      mode_r      <= LVL_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    mode_nxt     = mode_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.div_op   = op_r;
    cmd.lvl_mode = mode_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        op_nxt      = OP_TGT;
        state_nxt   = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          case (op_r)
            OP_TGT:  state_nxt = S_CHK;
            OP_F:    state_nxt = S_BLEND;
            OP_STEP: begin
              mode_nxt  = LVL_STEP;
              state_nxt = S_LVL;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (sts.tgt_lt || sts.limit_zero) begin
          mode_nxt  = LVL_TARGET;
          state_nxt = S_LVL;
        end else if (!sts.tgt_gt) begin
          mode_nxt  = LVL_HOLD;
          state_nxt = S_LVL;
        end else begin
          op_nxt    = OP_F;
          state_nxt = S_DIV_GO;
        end
      end
      S_BLEND: begin
        cmd.blend_en = 1'b1;
        state_nxt    = S_TMUL;
      end
      S_TMUL: begin
        cmd.t_load = 1'b1;
        state_nxt  = S_TCHK;
      end
      S_TCHK: begin
        if (sts.t_zero) begin
          mode_nxt  = LVL_TARGET;
          state_nxt = S_LVL;
        end else begin
          op_nxt    = OP_STEP;
          state_nxt = S_DIV_GO;
        end
      end
      S_LVL: begin
        cmd.lvl_we = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // wait for the result register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

  `TSR_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_PROD,
                  "accepted transaction did not start processing")
  `TSR_ASSERT_NXT(a_valid_from_out, !out_valid_r && (state_r != S_OUT), !out_valid_r,
                  "result valid raised outside the output step")
  `TSR_ASSERT_NXT(a_no_overwrite, (state_r == S_OUT) && out_valid_r && !out_tready,
                  state_r == S_OUT, "pending result overwritten")
  `TSR_ASSERT_IMP(a_done_in_wait, sts.div_done, state_r == S_DIV_WAIT,
                  "divider finished while controller not waiting")

endmodule

`default_nettype wire

// File: hdl/throttle_scale_speed_ramp_core.sv
// Processing time from input transaction to out_tvalid is set mostly by the shared divider,
// which yields one quotient bit per cycle (24 + 17 + 14 bits worst case); the blended
// time is divided by 1000 with a reciprocal multiply registered in t_r.
// A new item is taken only once the previous result is parked in the output register,
// which may still wait on out_tready; no item is taken while one is in progress.
// Reset (rst_n low, synchronous): level 0, config registers to defaults, no result pending.
`default_nettype none

module throttle_scale_speed_ramp_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,  // throttle_sample, vehicle_speed
  input  wire logic                            in_tuser,  // road_mode
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata, // throttle_level, pwm_duty
  output logic                                 out_tuser, // assist_blocked
  // config writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsr_pkg::SPEED_W-1:0]     cfg_data
);
  import tsr_pkg::*;

  tsr_cmd_t           cmd;
  tsr_sts_t           sts;
  logic [LEVEL_W-1:0] throttle_level;
  logic [DUTY_W-1:0]  pwm_duty;
  logic               assist_blocked;

  assign cfg_ready = 1'b1;

  tsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tsr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .throttle_sample (in_tdata[SAMPLE_W-1:0]),
    .vehicle_speed   (in_tdata[SAMPLE_W+SPEED_W-1:SAMPLE_W]),
    .road_mode       (in_tuser),
    .throttle_level  (throttle_level),
    .pwm_duty        (pwm_duty),
    .assist_blocked  (assist_blocked)
  );

  assign out_tdata = {2'b00, pwm_duty, throttle_level};
  assign out_tuser = assist_blocked;

endmodule

`default_nettype wire
